// ----- rtl/mvpa_pkg.sv -----
// package: constants, types and helpers of the matrix-vector product with argmax
package mvpa_pkg;

	localparam int MAX_ROWS  = 16;
	localparam int MAX_COLS  = 16;
	localparam int DATA_W    = 32;
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int CNT_W     = 5;
	localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int MAT_AW    = ROW_W + COL_W;
	localparam int PADDR_W   = 3;

	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN
	} mvpa_state_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] hi);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- rtl/mvpa_ram.sv -----
// generic simple dual-port ram with registered read
module mvpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/matrix_vector_product_argmax_core.sv -----
// top level: matrix-vector product with argmax over the row sums
//
// channel  | signals                                        | handshake
// ---------+------------------------------------------------+---------------------------
// input    | value                                          | start & !busy
// result   | row_index, row_sum, last, max_value, max_row   | result_valid, one cycle
// config   | psel, penable, pwrite, paddr, pwdata, prdata   | apb, pready tied high
//
// loading accepts one item whenever start is high and the block is not busy; after the last
// vector item the block is busy while one shared multiply-accumulate unit walks the matrix
// ram one element per cycle, results leave one per row from an output register.
// reset clears counts to 1, the load position and the sequencer; the stores are not cleared.
// the receiver cannot stall: each result is shown for exactly one cycle.
module matrix_vector_product_argmax_core
	import mvpa_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] value,
	output logic                     result_valid,
	output logic [ROW_W-1:0]         row_index,
	output logic signed [DATA_W-1:0] row_sum,
	output logic                     last,
	output logic signed [DATA_W-1:0] max_value,
	output logic [ROW_W-1:0]         max_row,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	mvpa_state_t state_q, state_d;

	logic [CNT_W-1:0] rows_q, cols_q;
	logic [CNT_W-1:0] rows_eff, cols_eff;
	logic [ROW_W-1:0] rows_m1;
	logic [COL_W-1:0] cols_m1;
	logic             cfg_wr;

	logic [CNT_W-1:0] load_row_q;
	logic [COL_W-1:0] load_col_q;
	logic             accept;
	logic             load_vec;
	logic             load_final;

	logic [ROW_W-1:0] iss_row_q;
	logic [COL_W-1:0] iss_col_q;
	logic             issue_en;
	logic             iss_final;

	logic [DATA_W-1:0] mat_rdata, vec_rdata;

	logic             v_s1, first_s1, lastc_s1;
	logic [ROW_W-1:0] row_s1;
	logic             v_s2, first_s2, lastc_s2;
	logic [ROW_W-1:0] row_s2;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] acc_q, acc_next;
	logic             v_s3;
	logic [ROW_W-1:0] row_s3;
	logic [DATA_W-1:0] sum_s3;

	logic [DATA_W-1:0] runmax_q, newmax;
	logic [ROW_W-1:0]  runmax_row_q, newmax_row;
	logic              take, fin;

	logic              valid_q, last_q;
	logic [ROW_W-1:0]  row_index_q, max_row_q;
	logic [DATA_W-1:0] row_sum_q, max_value_q;

	// configuration
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign rows_eff = clamp_count(rows_q, CNT_W'(MAX_ROWS));
	assign cols_eff = clamp_count(cols_q, CNT_W'(MAX_COLS));
	assign rows_m1  = ROW_W'(rows_eff - CNT_W'(1));
	assign cols_m1  = COL_W'(cols_eff - CNT_W'(1));
	assign prdata   = (paddr[2] == REG_COL_COUNT) ? 32'(cols_q) : 32'(rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CNT_W'(1);
			cols_q <= CNT_W'(1);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ROW_COUNT) begin
				rows_q <= pwdata[CNT_W-1:0];
			end else begin
				cols_q <= pwdata[CNT_W-1:0];
			end
		end
	end

	// loading
	assign accept     = start && !busy;
	assign load_vec   = (load_row_q == rows_eff);
	assign load_final = accept && load_vec && (load_col_q == cols_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_row_q <= '0;
			load_col_q <= '0;
		end else if (cfg_wr || load_final) begin
			load_row_q <= '0;
			load_col_q <= '0;
		end else if (accept) begin
			if (load_col_q == cols_m1) begin
				load_col_q <= '0;
				load_row_q <= load_row_q + CNT_W'(1);
			end else begin
				load_col_q <= load_col_q + COL_W'(1);
			end
		end
	end

	mvpa_ram #(.WIDTH(DATA_W), .DEPTH(MAT_DEPTH)) u_mat_ram (
		.clk   (clk),
		.we    (accept && !load_vec),
		.waddr ({load_row_q[ROW_W-1:0], load_col_q}),
		.wdata (value),
		.raddr ({iss_row_q, iss_col_q}),
		.rdata (mat_rdata)
	);

	mvpa_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_vec_ram (
		.clk   (clk),
		.we    (accept && load_vec),
		.waddr (load_col_q),
		.wdata (value),
		.raddr (iss_col_q),
		.rdata (vec_rdata)
	);

	// sequencer
	assign iss_final = (iss_row_q == rows_m1) && (iss_col_q == cols_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (load_final) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (iss_final) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (v_s3 && fin) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		busy     = 1'b1;
		issue_en = 1'b0;
		unique case (state_q)
			ST_LOAD:  busy = 1'b0;
			ST_ISSUE: issue_en = 1'b1;
			ST_DRAIN: busy = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_row_q <= '0;
			iss_col_q <= '0;
		end else if (issue_en) begin
			if (iss_col_q == cols_m1) begin
				iss_col_q <= '0;
				iss_row_q <= iss_final ? '0 : iss_row_q + ROW_W'(1);
			end else begin
				iss_col_q <= iss_col_q + COL_W'(1);
			end
		end
	end

	// multiply-accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && lastc_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (iss_col_q == '0);
		lastc_s1 <= (iss_col_q == cols_m1);
		row_s1   <= iss_row_q;
		first_s2 <= first_s1;
		lastc_s2 <= lastc_s1;
		row_s2   <= row_s1;
		prod_s2  <= mat_rdata * vec_rdata;
		if (v_s2) begin
			acc_q <= acc_next;
		end
		sum_s3 <= acc_next;
		row_s3 <= row_s2;
	end

	assign acc_next = (first_s2 ? '0 : acc_q) + prod_s2;

	// running maximum and result register
	assign fin        = (row_s3 == rows_m1);
	assign take       = (row_s3 == '0) || ($signed(sum_s3) > $signed(runmax_q));
	assign newmax     = take ? sum_s3 : runmax_q;
	assign newmax_row = take ? row_s3 : runmax_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runmax_q     <= '0;
			runmax_row_q <= '0;
			valid_q      <= 1'b0;
		end else begin
			valid_q <= v_s3;
			if (v_s3) begin
				runmax_q     <= newmax;
				runmax_row_q <= newmax_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		row_index_q <= row_s3;
		row_sum_q   <= sum_s3;
		last_q      <= fin;
		max_value_q <= fin ? newmax : '0;
		max_row_q   <= fin ? newmax_row : '0;
	end

	assign result_valid = valid_q;
	assign row_index    = row_index_q;
	assign row_sum      = row_sum_q;
	assign last         = last_q;
	assign max_value    = max_value_q;
	assign max_row      = max_row_q;

`ifndef NO_ASSERTIONS
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> state_q == ST_LOAD)
		else $error("final result while still computing");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> !(v_s1 || v_s2 || v_s3))
		else $error("pipeline busy while loading");

	a_max_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> max_row <= row_index)
		else $error("max row beyond final row");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> ({1'b0, iss_row_q} < rows_eff))
		else $error("issue row out of range");
`endif

endmodule
